// ===== src/ppp_pkg.sv =====
// Shared constants and helpers for the point perspective to pixel unit.
package ppp_pkg;

  localparam int COORD_W  = 32;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int VIEW_W   = 13;
  localparam int PIX_W    = 12;
  localparam int MAT_REGS = 6;
  localparam logic [VIEW_W-1:0] VIEW_MAX = 13'd4096;
  localparam logic [VIEW_W-1:0] WIDTH_RST = 13'd1920;
  localparam logic [VIEW_W-1:0] HEIGHT_RST = 13'd1200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X_FIRST  = 3'd0,
    CFG_ROW_X_SECOND = 3'd1,
    CFG_ROW_Y_FIRST  = 3'd2,
    CFG_ROW_Y_SECOND = 3'd3,
    CFG_ROW_W_FIRST  = 3'd4,
    CFG_ROW_W_SECOND = 3'd5,
    CFG_WIDTH        = 3'd6,
    CFG_HEIGHT       = 3'd7
  } cfg_idx_t;

  function automatic logic [VIEW_W-1:0] clamp_view(input logic [VIEW_W-1:0] v);
    clamp_view = (v > VIEW_MAX) ? VIEW_MAX : v;
  endfunction

endpackage

// ===== src/ppp_clip.sv =====
// Clip-space transform: nine products, then the three row sums, in two stages.
module ppp_clip import ppp_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int SW = 66 - FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       en_mul,
  input  logic                       en_sum,
  input  logic signed [COORD_W-1:0]  pt_x,
  input  logic signed [COORD_W-1:0]  pt_y,
  input  logic signed [COORD_W-1:0]  pt_z,
  input  logic [CFG_W-1:0]           mat [MAT_REGS],
  output logic signed [SW-1:0]       cx_r,
  output logic signed [SW-1:0]       cy_r,
  output logic signed [SW-1:0]       cw_r
);

  logic signed [2*COORD_W-1:0] prod_r [9];
  logic signed [COORD_W-1:0]   trans_r [3];
  logic signed [SW-1:0]        sum_nxt [3];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[3*r]   <= $signed(mat[2*r][31:0])   * pt_x;
        prod_r[3*r+1] <= $signed(mat[2*r][63:32])  * pt_y;
        prod_r[3*r+2] <= $signed(mat[2*r+1][31:0]) * pt_z;
        trans_r[r]    <= $signed(mat[2*r+1][63:32]);
      end
    end
  end

  always_comb begin
    logic signed [2*COORD_W-1:0] s0, s1, s2;
    for (int r = 0; r < 3; r++) begin
      s0 = prod_r[3*r]   >>> FRAC_BITS;
      s1 = prod_r[3*r+1] >>> FRAC_BITS;
      s2 = prod_r[3*r+2] >>> FRAC_BITS;
      sum_nxt[r] = s0[SW-1:0] + s1[SW-1:0] + s2[SW-1:0]
                 + SW'(trans_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      cx_r <= sum_nxt[0];
      cy_r <= sum_nxt[1];
      cw_r <= sum_nxt[2];
    end
  end

endmodule

// ===== src/ppp_div_step.sv =====
// One registered step of the restoring scale-and-divide for one axis.
module ppp_div_step import ppp_pkg::*; #(
  parameter int DW = 50
) (
  input  logic              clk,
  input  logic              en,
  input  logic              n_bit,
  input  logic [DW-1:0]     d_in,
  input  logic [DW-1:0]     mag_in,
  input  logic [DW+1:0]     rem_in,
  input  logic [VIEW_W-1:0] quo_in,
  output logic [DW-1:0]     d_r,
  output logic [DW-1:0]     mag_r,
  output logic [DW+1:0]     rem_r,
  output logic [VIEW_W-1:0] quo_r
);

  logic [DW+1:0]     rem_nxt;
  logic [VIEW_W-1:0] quo_nxt;

  always_comb begin
    logic [DW+1:0] d_ext;
    d_ext   = {2'b00, d_in};
    rem_nxt = {rem_in[DW:0], 1'b0};
    quo_nxt = {quo_in[VIEW_W-2:0], 1'b0};
    if (rem_nxt >= d_ext) begin
      rem_nxt = rem_nxt - d_ext;
      quo_nxt = quo_nxt + VIEW_W'(1);
    end
    if (n_bit) begin
      rem_nxt = rem_nxt + {2'b00, mag_in};
      if (rem_nxt >= d_ext) begin
        rem_nxt = rem_nxt - d_ext;
        quo_nxt = quo_nxt + VIEW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_in;
      mag_r <= mag_in;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

// ===== src/point_perspective_to_pixel_unit.sv =====
// Throughput: one word per cycle while out_stall is low; two product/sum
// stages, one setup stage, thirteen scale-and-divide steps (one per viewport
// bit) and an output stage.
// Reset (synchronous, rst_n low) empties the pipeline, clears the matrix
// registers and sets the viewport to 1920 by 1200.
module point_perspective_to_pixel_unit import ppp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_in_front,
  output logic                      out_on_screen,
  output logic [PIX_W-1:0]          out_pixel_x,
  output logic [PIX_W-1:0]          out_pixel_y
);

  localparam int SW = 66 - FRAC_BITS;
  localparam int DW = SW;
  localparam int NDIV = VIEW_W;
  localparam int NST = 4 + NDIV;
  localparam int ST_PREP = 2;
  localparam int ST_DIV0 = 3;
  localparam int ST_OUT = NST - 1;

  logic [CFG_W-1:0]  mat_r [MAT_REGS];
  logic [VIEW_W-1:0] wdt_r, hgt_r;
  logic [VIEW_W-1:0] wdt, hgt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_REGS; i++) mat_r[i] <= '0;
      wdt_r <= WIDTH_RST;
      hgt_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROW_X_FIRST:  mat_r[0] <= cfg_data;
        CFG_ROW_X_SECOND: mat_r[1] <= cfg_data;
        CFG_ROW_Y_FIRST:  mat_r[2] <= cfg_data;
        CFG_ROW_Y_SECOND: mat_r[3] <= cfg_data;
        CFG_ROW_W_FIRST:  mat_r[4] <= cfg_data;
        CFG_ROW_W_SECOND: mat_r[5] <= cfg_data;
        CFG_WIDTH:        wdt_r <= cfg_data[VIEW_W-1:0];
        CFG_HEIGHT:       hgt_r <= cfg_data[VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  assign wdt = clamp_view(wdt_r);
  assign hgt = clamp_view(hgt_r);

  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST-2; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_stall = !rdy[0];

  logic signed [SW-1:0] cx, cy, cw;

  ppp_clip #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_clip (
    .clk    (clk),
    .en_mul (rdy[0]),
    .en_sum (rdy[1]),
    .pt_x   (in_point_x),
    .pt_y   (in_point_y),
    .pt_z   (in_point_z),
    .mat    (mat_r),
    .cx_r   (cx),
    .cy_r   (cy),
    .cw_r   (cw)
  );

  logic signed [SW:0] numx, numy, den;
  logic [DW-1:0] d_r, magx_r, magy_r;
  logic front_r, okx_r, oky_r, negx_r, negy_r;

  always_comb begin
    numx = {cx[SW-1], cx} + {cw[SW-1], cw};
    numy = {cw[SW-1], cw} - {cy[SW-1], cy};
    den  = {cw, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PREP]) begin
      front_r <= (cw > 0);
      okx_r   <= !(numx >= den || numx <= -den);
      oky_r   <= !(numy >= den || numy <= -den);
      negx_r  <= numx[SW];
      negy_r  <= numy[SW];
      magx_r  <= numx[SW] ? DW'(-numx) : DW'(numx);
      magy_r  <= numy[SW] ? DW'(-numy) : DW'(numy);
      d_r     <= DW'(den);
    end
  end

  logic [DW-1:0]     dx_s [NDIV+1];
  logic [DW-1:0]     dy_s [NDIV+1];
  logic [DW-1:0]     mx_s [NDIV+1];
  logic [DW-1:0]     my_s [NDIV+1];
  logic [DW+1:0]     rx_s [NDIV+1];
  logic [DW+1:0]     ry_s [NDIV+1];
  logic [VIEW_W-1:0] qx_s [NDIV+1];
  logic [VIEW_W-1:0] qy_s [NDIV+1];
  logic [NDIV:0]     front_s, okx_s, oky_s, negx_s, negy_s;

  assign dx_s[0] = d_r;
  assign dy_s[0] = d_r;
  assign mx_s[0] = magx_r;
  assign my_s[0] = magy_r;
  assign rx_s[0] = '0;
  assign ry_s[0] = '0;
  assign qx_s[0] = '0;
  assign qy_s[0] = '0;
  assign front_s[0] = front_r;
  assign okx_s[0] = okx_r;
  assign oky_s[0] = oky_r;
  assign negx_s[0] = negx_r;
  assign negy_s[0] = negy_r;

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    ppp_div_step #(.DW(DW)) u_x (
      .clk    (clk),
      .en     (rdy[ST_DIV0+j]),
      .n_bit  (wdt[NDIV-1-j]),
      .d_in   (dx_s[j]),
      .mag_in (mx_s[j]),
      .rem_in (rx_s[j]),
      .quo_in (qx_s[j]),
      .d_r    (dx_s[j+1]),
      .mag_r  (mx_s[j+1]),
      .rem_r  (rx_s[j+1]),
      .quo_r  (qx_s[j+1])
    );
    ppp_div_step #(.DW(DW)) u_y (
      .clk    (clk),
      .en     (rdy[ST_DIV0+j]),
      .n_bit  (hgt[NDIV-1-j]),
      .d_in   (dy_s[j]),
      .mag_in (my_s[j]),
      .rem_in (ry_s[j]),
      .quo_in (qy_s[j]),
      .d_r    (dy_s[j+1]),
      .mag_r  (my_s[j+1]),
      .rem_r  (ry_s[j+1]),
      .quo_r  (qy_s[j+1])
    );
    logic front_sr, okx_sr, oky_sr, negx_sr, negy_sr;
    always_ff @(posedge clk) begin
      if (rdy[ST_DIV0+j]) begin
        front_sr <= front_s[j];
        okx_sr   <= okx_s[j];
        oky_sr   <= oky_s[j];
        negx_sr  <= negx_s[j];
        negy_sr  <= negy_s[j];
      end
    end
    assign front_s[j+1] = front_sr;
    assign okx_s[j+1] = okx_sr;
    assign oky_s[j+1] = oky_sr;
    assign negx_s[j+1] = negx_sr;
    assign negy_s[j+1] = negy_sr;
  end

  logic fin_x, fin_y, on_nxt;
  logic front_o_r, on_o_r;
  logic [PIX_W-1:0] px_o_r, py_o_r;

  assign fin_x = okx_s[NDIV] && !(negx_s[NDIV] && qx_s[NDIV] != '0) && qx_s[NDIV] < wdt;
  assign fin_y = oky_s[NDIV] && !(negy_s[NDIV] && qy_s[NDIV] != '0) && qy_s[NDIV] < hgt;
  assign on_nxt = front_s[NDIV] && fin_x && fin_y;

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      front_o_r <= front_s[NDIV];
      on_o_r    <= on_nxt;
      px_o_r    <= on_nxt ? qx_s[NDIV][PIX_W-1:0] : '0;
      py_o_r    <= on_nxt ? qy_s[NDIV][PIX_W-1:0] : '0;
    end
  end

  assign out_valid = v_r[ST_OUT];
  assign out_in_front = front_o_r;
  assign out_on_screen = on_o_r;
  assign out_pixel_x = px_o_r;
  assign out_pixel_y = py_o_r;

  a_on_needs_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_screen |-> out_in_front)
    else $error("on_screen without in_front");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_on_screen |-> out_pixel_x == '0 && out_pixel_y == '0)
    else $error("pixel not zero while off screen");

  a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_screen |-> {1'b0, out_pixel_x} < wdt && {1'b0, out_pixel_y} < hgt)
    else $error("pixel outside viewport");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the point perspective to pixel unit.
module testbench import ppp_pkg::*;;

  localparam int FRAC = 16;
  localparam int LATENCY = 17;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic             in_front;
    logic             on_screen;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_word_t;

  class pixel_scoreboard;
    logic [CFG_W-1:0] matrix[MAT_REGS];
    logic [VIEW_W-1:0] view_w, view_h;
    pixel_word_t pending[$];
    int errors;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      view_w = WIDTH_RST;
      view_h = HEIGHT_RST;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      if (idx == CFG_WIDTH) view_w = val[VIEW_W-1:0];
      else if (idx == CFG_HEIGHT) view_h = val[VIEW_W-1:0];
      else matrix[idx] = val;
    endfunction

    function longint row_sum(int r, longint x, longint y, longint z);
      logic [CFG_W-1:0] a, b;
      longint cx, cy, cz, ct;
      a = matrix[2*r];
      b = matrix[2*r+1];
      cx = longint'($signed(a[31:0]));
      cy = longint'($signed(a[63:32]));
      cz = longint'($signed(b[31:0]));
      ct = longint'($signed(b[63:32]));
      return ((cx * x) >>> FRAC) + ((cy * y) >>> FRAC) + ((cz * z) >>> FRAC) + ct;
    endfunction

    // Returns -1 when the pixel falls outside [0, n).
    function longint scale(longint num, longint den, longint n);
      logic signed [127:0] p, q;
      if (num >= den || num <= -den) return -1;
      p = 128'(num) * 128'(n);
      q = p / 128'(den);
      if (q < 0 || q >= n) return -1;
      return longint'(q);
    endfunction

    function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint x, y, z, cx, cy, cw, w, h, qx, qy;
      pixel_word_t e;
      x = longint'($signed(px));
      y = longint'($signed(py));
      z = longint'($signed(pz));
      cx = row_sum(0, x, y, z);
      cy = row_sum(1, x, y, z);
      cw = row_sum(2, x, y, z);
      w = (view_w > VIEW_MAX) ? VIEW_MAX : view_w;
      h = (view_h > VIEW_MAX) ? VIEW_MAX : view_h;
      e = '0;
      e.in_front = cw > 0;
      if (cw > 0) begin
        qx = scale(cx + cw, 2 * cw, w);
        qy = scale(cw - cy, 2 * cw, h);
        if (qx >= 0 && qy >= 0) begin
          e.on_screen = 1'b1;
          e.pixel_x = qx[PIX_W-1:0];
          e.pixel_y = qy[PIX_W-1:0];
        end
      end
      pending = {pending, e};
    endfunction

    function void check_word(pixel_word_t a);
      pixel_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.in_front !== e.in_front) begin
        $error("in_front expected %0d actual %0d", e.in_front, a.in_front); errors++;
      end
      if (a.on_screen !== e.on_screen) begin
        $error("on_screen expected %0d actual %0d", e.on_screen, a.on_screen); errors++;
      end
      if (a.pixel_x !== e.pixel_x) begin
        $error("pixel_x expected %0d actual %0d", e.pixel_x, a.pixel_x); errors++;
      end
      if (a.pixel_y !== e.pixel_y) begin
        $error("pixel_y expected %0d actual %0d", e.pixel_y, a.pixel_y); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_in_front, out_on_screen;
  logic [PIX_W-1:0] out_pixel_x, out_pixel_y;

  pixel_scoreboard sb = new();
  longint cycles = 0;
  bit stall_on = 1'b1;

  always #5 clk = ~clk;

  point_perspective_to_pixel_unit u_top (.*);

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word({out_in_front, out_on_screen, out_pixel_x, out_pixel_y});
  end

  int out_hold = 0;
  always @(posedge clk) begin
    if (!stall_on) out_stall <= 1'b0;
    else if (out_hold > 0) out_hold <= out_hold - 1;
    else if ($urandom_range(0, 3) == 0) begin
      out_stall <= ~out_stall;
      out_hold <= gap_len();
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
    int g;
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (in_stall);
    sb.note_point(x, y, z);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] pair(logic [31:0] lo, logic [31:0] hi);
    return {hi, lo};
  endfunction

  function automatic logic [31:0] near_coord();
    return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
  endfunction

  task automatic load_camera(logic [12:0] w, logic [12:0] h);
    write_reg(CFG_ROW_X_FIRST, pair(32'h0001_0000, 32'h0));
    write_reg(CFG_ROW_X_SECOND, pair(32'h0, 32'h0));
    write_reg(CFG_ROW_Y_FIRST, pair(32'h0, 32'h0001_0000));
    write_reg(CFG_ROW_Y_SECOND, pair(32'h0, 32'h0));
    write_reg(CFG_ROW_W_FIRST, pair(32'h0, 32'h0));
    write_reg(CFG_ROW_W_SECOND, pair(32'h0000_8000, 32'h0004_0000));
    write_reg(CFG_WIDTH, 64'(w));
    write_reg(CFG_HEIGHT, 64'(h));
  endtask

  task automatic random_phase(int n, bit full_random);
    for (int i = 0; i < n; i++) begin
      if (full_random || $urandom_range(0, 4) == 0)
        send_point($urandom(), $urandom(), $urandom(), 1);
      else
        send_point(near_coord(), near_coord(), near_coord(), $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Reset matrix: w is zero, so every point is behind the camera.
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0, 0);
    drain();
    load_camera(13'd1920, 13'd1200);
    send_point(32'h0, 32'h0, 32'h0, 0);
    send_point(32'hfffc_0000, 32'h0004_0000, 32'h0, 0);
    send_point(32'hfffb_ffff, 32'h0, 32'h0, 0);
    send_point(32'h0, 32'h0004_0001, 32'h0, 0);
    send_point(32'h0003_ffff, 32'hfffc_0001, 32'h0, 0);
    send_point(32'h0004_0000, 32'hfffc_0000, 32'h0, 0);
    send_point(32'h0, 32'h0, 32'hfff8_0000, 0);
    send_point(32'h0, 32'h0, 32'h8000_0000, 0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    drain();
    write_reg(CFG_WIDTH, 64'd0);
    write_reg(CFG_HEIGHT, 64'h1fff);
    send_point(32'h0, 32'h0, 32'h0, 0);
    drain();
    write_reg(CFG_WIDTH, 64'hffff_ffff_ffff_1fff);
    write_reg(CFG_HEIGHT, 64'd1);
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0, 0);
    send_point(32'hfffc_0000, 32'h0004_0000, 32'h0, 0);
    drain();
    write_reg(CFG_WIDTH, 64'd4096);
    write_reg(CFG_HEIGHT, 64'd4096);
    random_phase(100, 0);
    // Sender holds off until the pipe is empty.
    drain();
    random_phase(60, 0);
    drain();
    stall_on = 1'b0;
    random_phase(40, 0);
    stall_on = 1'b1;
    drain();
    load_camera(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    random_phase(80, 0);
    drain();
    for (int r = 0; r < MAT_REGS; r++) write_reg(cfg_idx_t'(r), {$urandom(), $urandom()});
    write_reg(CFG_WIDTH, 64'($urandom()));
    write_reg(CFG_HEIGHT, 64'($urandom()));
    random_phase(60, 1);
    drain();
    for (int r = 0; r < MAT_REGS; r++)
      write_reg(cfg_idx_t'(r), pair(near_coord(), near_coord()));
    write_reg(CFG_WIDTH, 64'd1);
    write_reg(CFG_HEIGHT, 64'd4096);
    random_phase(60, 0);
    drain();
    if (sb.errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
